FILE: rtl/acpu_pkg.sv
// shared types, constants and saturating arithmetic for the allen-cahn point update
package acpu_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int FRAC_BITS       = 24;
    localparam int OTHERS_WIDTH    = DATA_WIDTH - 1;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int PROD_W          = 2 * DATA_WIDTH;
    localparam int WIDE_W          = 2 * DATA_WIDTH + 2;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [WIDE_W-1:0]     t_wide;

    typedef struct packed {
        logic                  clip;
        logic [DATA_WIDTH-1:0] value;
    } t_sat;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ALPHA     = 3'd0,
        CFG_BETA      = 3'd1,
        CFG_GAMMA     = 3'd2,
        CFG_KAPPA     = 3'd3,
        CFG_STEP_RATE = 3'd4,
        CFG_INV_DX_SQ = 3'd5,
        CFG_INV_DY_SQ = 3'd6
    } t_cfg_idx;

    localparam logic [DATA_WIDTH-1:0] ONE_FIX = DATA_WIDTH'(64'd1 << FRAC_BITS);
    localparam logic [DATA_WIDTH-1:0] STEP_RATE_RESET =
        DATA_WIDTH'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam t_wide ROUND_HALF = t_wide'(64'd1 << (FRAC_BITS - 1));

    function automatic t_wide wext(input t_data a);
        return {{(WIDE_W-DATA_WIDTH){a[DATA_WIDTH-1]}}, a};
    endfunction

    // clip a wide exact value to the data range and flag it
    function automatic t_sat sat_wide(input t_wide x);
        t_sat                        r;
        logic [WIDE_W-DATA_WIDTH:0]  top;
        top = x[WIDE_W-1:DATA_WIDTH-1];
        if ((&top) || !(|top)) begin
            r.clip  = 1'b0;
            r.value = x[DATA_WIDTH-1:0];
        end else begin
            r.clip  = 1'b1;
            r.value = x[WIDE_W-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                  : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic t_sat sat_add(input t_data a, input t_data b);
        return sat_wide(wext(a) + wext(b));
    endfunction

    function automatic t_sat sat_sub(input t_data a, input t_data b);
        return sat_wide(wext(a) - wext(b));
    endfunction

    // (2*(p1+m1) + (p2+m2) - 6c + 2) >>> 2, then clipped
    function automatic t_sat lap_dir(input t_data c, input t_data p1, input t_data m1,
                                     input t_data p2, input t_data m2);
        t_wide num;
        num = ((wext(p1) + wext(m1)) <<< 1) + wext(p2) + wext(m2)
            - (wext(c) <<< 2) - (wext(c) <<< 1) + t_wide'(2);
        return sat_wide(num >>> 2);
    endfunction

endpackage

FILE: rtl/allen_cahn_point_update.sv
// top level: pipelined allen-cahn point update with coefficient registers
//
// One cell update per transfer. The input channel (i_in_valid / o_in_ready) carries
// the centre value, the eight stencil neighbours and the sum of squares of the other
// order parameters; the output channel (o_out_valid / i_out_ready) returns the new
// value and a flag that is set when any intermediate stage had to clip.
// Coefficients are loaded through i_cfg_we / i_cfg_index / i_cfg_data, one register
// a cycle; they must only change while the pipeline is empty.
// One item can enter every cycle while the output is not stalled. Each of the
// seven register stages holds at most one fixed-point multiply followed by rounding
// and clipping, which sets the stage depth.
// Each stage has its own valid bit and advances whenever the stage after it has
// room, so gaps in the stream close up under a stall. When the receiver holds
// i_out_ready low the output register keeps its result, and input transfers stop
// only once every stage is full.
// Synchronous active-low reset empties the pipeline and loads the default
// coefficients (1.0 everywhere, step rate 0.1).
module allen_cahn_point_update (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [acpu_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [acpu_pkg::DATA_WIDTH-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  acpu_pkg::t_data                        i_centre,
    input  acpu_pkg::t_data                        i_east_one,
    input  acpu_pkg::t_data                        i_west_one,
    input  acpu_pkg::t_data                        i_east_two,
    input  acpu_pkg::t_data                        i_west_two,
    input  acpu_pkg::t_data                        i_north_one,
    input  acpu_pkg::t_data                        i_south_one,
    input  acpu_pkg::t_data                        i_north_two,
    input  acpu_pkg::t_data                        i_south_two,
    input  logic [acpu_pkg::OTHERS_WIDTH-1:0]      i_others_square_sum,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output acpu_pkg::t_data                        o_new_value,
    output logic                                   o_saturated
);

    localparam int NUM_STAGES = 7;

    // coefficient registers
    acpu_pkg::t_data r_alpha, r_beta, r_gamma, r_kappa, r_step_rate, r_inv_dx, r_inv_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= acpu_pkg::ONE_FIX;
            r_beta      <= acpu_pkg::ONE_FIX;
            r_gamma     <= acpu_pkg::ONE_FIX;
            r_kappa     <= acpu_pkg::ONE_FIX;
            r_step_rate <= acpu_pkg::STEP_RATE_RESET;
            r_inv_dx    <= acpu_pkg::ONE_FIX;
            r_inv_dy    <= acpu_pkg::ONE_FIX;
        end else if (i_cfg_we) begin
            unique case (acpu_pkg::t_cfg_idx'(i_cfg_index))
                acpu_pkg::CFG_ALPHA:     r_alpha     <= i_cfg_data;
                acpu_pkg::CFG_BETA:      r_beta      <= i_cfg_data;
                acpu_pkg::CFG_GAMMA:     r_gamma     <= i_cfg_data;
                acpu_pkg::CFG_KAPPA:     r_kappa     <= i_cfg_data;
                acpu_pkg::CFG_STEP_RATE: r_step_rate <= i_cfg_data;
                acpu_pkg::CFG_INV_DX_SQ: r_inv_dx    <= i_cfg_data;
                acpu_pkg::CFG_INV_DY_SQ: r_inv_dy    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-stage valid bits and advance enables
    logic [NUM_STAGES:1] r_vld;
    logic [NUM_STAGES:1] en;

    always_comb begin
        en[NUM_STAGES] = !r_vld[NUM_STAGES] || i_out_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_in_ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: c^2, alpha*c, gamma*c, laplacian numerators
    acpu_pkg::t_sat s1_c2, s1_ac, s1_g, s1_ndx, s1_ndy;

    acpu_fmul u_c2 (.i_a(i_centre), .i_b(i_centre), .o_res(s1_c2));
    acpu_fmul u_ac (.i_a(r_alpha),  .i_b(i_centre), .o_res(s1_ac));
    acpu_fmul u_g  (.i_a(r_gamma),  .i_b(i_centre), .o_res(s1_g));

    assign s1_ndx = acpu_pkg::lap_dir(i_centre, i_east_one, i_west_one, i_east_two, i_west_two);
    assign s1_ndy = acpu_pkg::lap_dir(i_centre, i_north_one, i_south_one,
                                      i_north_two, i_south_two);

    acpu_pkg::t_data                    r1_c, r1_c2, r1_ac, r1_g, r1_ndx, r1_ndy;
    logic [acpu_pkg::OTHERS_WIDTH-1:0]  r1_oth;
    logic                               r1_clip;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_c    <= i_centre;
            r1_c2   <= s1_c2.value;
            r1_ac   <= s1_ac.value;
            r1_g    <= s1_g.value;
            r1_ndx  <= s1_ndx.value;
            r1_ndy  <= s1_ndy.value;
            r1_oth  <= i_others_square_sum;
            r1_clip <= s1_c2.clip | s1_ac.clip | s1_g.clip | s1_ndx.clip | s1_ndy.clip;
        end
    end

    // stage 2: c^3, gamma*c*others, directional laplacians
    acpu_pkg::t_sat  s2_c3, s2_go, s2_lx, s2_ly;
    acpu_pkg::t_data oth_ext;

    assign oth_ext = {1'b0, r1_oth};

    acpu_fmul u_c3 (.i_a(r1_c2),  .i_b(r1_c),     .o_res(s2_c3));
    acpu_fmul u_go (.i_a(r1_g),   .i_b(oth_ext),  .o_res(s2_go));
    acpu_fmul u_lx (.i_a(r1_ndx), .i_b(r_inv_dx), .o_res(s2_lx));
    acpu_fmul u_ly (.i_a(r1_ndy), .i_b(r_inv_dy), .o_res(s2_ly));

    acpu_pkg::t_data r2_c, r2_ac, r2_c3, r2_go, r2_lx, r2_ly;
    logic            r2_clip;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_c    <= r1_c;
            r2_ac   <= r1_ac;
            r2_c3   <= s2_c3.value;
            r2_go   <= s2_go.value;
            r2_lx   <= s2_lx.value;
            r2_ly   <= s2_ly.value;
            r2_clip <= r1_clip | s2_c3.clip | s2_go.clip | s2_lx.clip | s2_ly.clip;
        end
    end

    // stage 3: beta*c^3, doubled interaction term, total laplacian
    acpu_pkg::t_sat s3_b3, s3_g2, s3_lap;

    acpu_fmul u_b3 (.i_a(r_beta), .i_b(r2_c3), .o_res(s3_b3));

    assign s3_g2  = acpu_pkg::sat_add(r2_go, r2_go);
    assign s3_lap = acpu_pkg::sat_add(r2_lx, r2_ly);

    acpu_pkg::t_data r3_c, r3_ac, r3_b3, r3_g2, r3_lap;
    logic            r3_clip;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_c    <= r2_c;
            r3_ac   <= r2_ac;
            r3_b3   <= s3_b3.value;
            r3_g2   <= s3_g2.value;
            r3_lap  <= s3_lap.value;
            r3_clip <= r2_clip | s3_b3.clip | s3_g2.clip | s3_lap.clip;
        end
    end

    // stage 4: bulk term and kappa*laplacian
    acpu_pkg::t_sat s4_d, s4_bulk, s4_k;

    assign s4_d    = acpu_pkg::sat_sub(r3_b3, r3_ac);
    assign s4_bulk = acpu_pkg::sat_add(s4_d.value, r3_g2);

    acpu_fmul u_k (.i_a(r_kappa), .i_b(r3_lap), .o_res(s4_k));

    acpu_pkg::t_data r4_c, r4_bulk, r4_k;
    logic            r4_clip;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_c    <= r3_c;
            r4_bulk <= s4_bulk.value;
            r4_k    <= s4_k.value;
            r4_clip <= r3_clip | s4_d.clip | s4_bulk.clip | s4_k.clip;
        end
    end

    // stage 5: driving force
    acpu_pkg::t_sat s5_diff;

    assign s5_diff = acpu_pkg::sat_sub(r4_k, r4_bulk);

    acpu_pkg::t_data r5_c, r5_diff;
    logic            r5_clip;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_c    <= r4_c;
            r5_diff <= s5_diff.value;
            r5_clip <= r4_clip | s5_diff.clip;
        end
    end

    // stage 6: scale by step rate
    acpu_pkg::t_sat s6_u;

    acpu_fmul u_u (.i_a(r_step_rate), .i_b(r5_diff), .o_res(s6_u));

    acpu_pkg::t_data r6_c, r6_u;
    logic            r6_clip;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_c    <= r5_c;
            r6_u    <= s6_u.value;
            r6_clip <= r5_clip | s6_u.clip;
        end
    end

    // stage 7: output register
    acpu_pkg::t_sat  s7_res;
    acpu_pkg::t_data r7_res;
    logic            r7_sat;

    assign s7_res = acpu_pkg::sat_add(r6_c, r6_u);

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_res <= s7_res.value;
            r7_sat <= r6_clip | s7_res.clip;
        end
    end

    assign o_out_valid = r_vld[NUM_STAGES];
    assign o_new_value = r7_res;
    assign o_saturated = r7_sat;

    // input is refused only when the whole pipeline is full behind a stalled output
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input refused while pipeline has room");

    // a clip seen in an earlier stage reaches the output flag
    a_clip_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en[NUM_STAGES] && r_vld[NUM_STAGES-1] && r6_clip) |=> o_saturated)
        else $error("clip flag lost at output stage");

    // a stalled first stage keeps its item
    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !en[2]) |=> (r_vld[1] && $stable(r1_c) && $stable(r1_clip)))
        else $error("stage one item changed during stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

FILE: rtl/acpu_fmul.sv
// fixed-point multiply: exact product, round half up, clip to data range
module acpu_fmul (
    input  acpu_pkg::t_data i_a,
    input  acpu_pkg::t_data i_b,
    output acpu_pkg::t_sat  o_res
);

    logic signed [acpu_pkg::PROD_W-1:0] prod;
    acpu_pkg::t_wide                    prod_ext;
    acpu_pkg::t_wide                    rnd;

    assign prod     = i_a * i_b;
    assign prod_ext = {{(acpu_pkg::WIDE_W-acpu_pkg::PROD_W){prod[acpu_pkg::PROD_W-1]}}, prod};
    assign rnd      = (prod_ext + acpu_pkg::ROUND_HALF) >>> acpu_pkg::FRAC_BITS;
    assign o_res    = acpu_pkg::sat_wide(rnd);

endmodule
